@@ rtl/adtp_pkg.sv @@
// Shared types and constants of the audio-driven tesseract projection block.
package adtp_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int PEAK_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int VIDX_W     = 4;
	localparam int COORD_W    = 12;
	localparam int PHASE_W    = 16;
	localparam int VOL_W      = 16;
	localparam int TRIG_W     = 17;
	localparam int PROJ_NUM_W = 39;
	localparam int PROJ_DEN_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEFT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_RIGHT = 2'd1;

	localparam logic [VOL_W-1:0] VOL_ONE  = 16'd32768;
	localparam logic [37:0]      RECIP10  = 38'd419431;
	localparam logic [VIDX_W-1:0] LAST_VTX = 4'd15;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_DEN,
		OP_SM1,
		OP_SM2,
		OP_PHASE,
		OP_SIN,
		OP_ROT,
		OP_DEN3,
		OP_MUL
	} op_t;

	typedef enum logic [2:0] {
		DSEL_VOL,
		DSEL_X,
		DSEL_Y,
		DSEL_Z,
		DSEL_SX,
		DSEL_SY
	} dsel_t;

	typedef struct packed {
		logic              acc;
		op_t               op;
		logic [2:0]        step;
		logic [2:0]        trig;
		logic [VIDX_W-1:0] vert;
		logic              div_start;
		dsel_t             dsel;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic div_done;
	} sts_t;

	function automatic logic [PHASE_W-1:0] phase_step(input logic [15:0] base,
			input logic [15:0] gain, input logic [VOL_W-1:0] vol);
		logic [31:0] p;
		p = 32'(gain) * 32'(vol) + 32'd16384;
		return base + 16'(p >> 15);
	endfunction

endpackage

@@ rtl/adtp_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module adtp_div #(
	parameter int NW = 50,
	parameter int DW = 36
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] sh_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, sh_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			sh_q  <= {sh_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

endmodule

@@ rtl/adtp_dp.sv @@
// Datapath: frame accumulation, volume, phases, sine, rotation and projection.
module adtp_dp #(
	parameter int FRAME_MAX   = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [adtp_pkg::SAMPLE_W-1:0]       left_sample,
	input  logic [adtp_pkg::SAMPLE_W-1:0]       right_sample,
	input  logic                                last_in_frame,
	input  logic                                cfg_wr,
	input  logic [adtp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [adtp_pkg::PEAK_W-1:0]         cfg_data,
	input  adtp_pkg::cmd_t                      cmd,
	output adtp_pkg::sts_t                      sts,
	output logic signed [adtp_pkg::COORD_W-1:0] screen_x,
	output logic signed [adtp_pkg::COORD_W-1:0] screen_y
);
	import adtp_pkg::*;

	localparam int SW     = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam int CNT_W  = $clog2(FRAME_MAX + 1);
	localparam int ABS_W  = SW + 1 + CNT_W;
	localparam int DEN_VW = CNT_W + PEAK_W + 1;
	localparam int NW     = (ABS_W + 15 > PROJ_NUM_W) ? ABS_W + 15 : PROJ_NUM_W;
	localparam int DW     = (DEN_VW > PROJ_DEN_W) ? DEN_VW : PROJ_DEN_W;

	function automatic logic signed [17:0] pm(input logic b, input logic signed [16:0] v);
		logic signed [17:0] e;
		e = {v[16], v};
		return b ? e : -e;
	endfunction

	function automatic logic [17:0] abs18(input logic [17:0] a);
		return a[17] ? (~a + 18'd1) : a;
	endfunction

	function automatic logic [24:0] abs25(input logic [24:0] a);
		return a[24] ? (~a + 25'd1) : a;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat12(input logic signed [13:0] v);
		if (v > 14'sd2047)
			return 12'sh7FF;
		if (v < -14'sd2048)
			return 12'sh800;
		return v[11:0];
	endfunction

	logic [PEAK_W-1:0]        peak_l_q, peak_r_q;
	logic [CNT_W-1:0]         count_q;
	logic [ABS_W-1:0]         abs_sum_q;
	logic [DEN_VW-1:0]        den_q;
	logic [VOL_W-1:0]         vol_q, smoothed_q;
	logic [18:0]              sm_n_q;
	logic [PHASE_W-1:0]       ph_xy_q, ph_zw_q, ph_xw_q;
	logic [16:0]              d4_q;
	logic [14:0]              scale_q;
	logic [14:0]              t_q, t2_q;
	logic [15:0]              r_q;
	logic                     sneg_q;
	logic signed [TRIG_W-1:0] trig_q [6];
	logic signed [17:0]       x1_q, y1_q, z2_q, w2_q, x3_q;
	logic signed [35:0]       pa_q, pb_q;
	logic [16:0]              den4_q;
	logic signed [24:0]       x3d_q, y3d_q, z3d_q;
	logic [31:0]              den3_q;
	logic [38:0]              prod_q;
	logic                     prod_neg_q;
	dsel_t                    dsel_l_q;
	logic                     neg_l_q;
	logic signed [COORD_W-1:0] sx_q, sy_q;

	logic [SW-1:0]  l_raw, r_raw, l_abs, r_abs;
	logic [SW:0]    pair;
	logic [24:0]    psum;
	logic [NW-1:0]  div_num, quo;
	logic [DW-1:0]  div_den;
	logic           div_neg, div_done;
	logic [PHASE_W-1:0] pp;
	logic [14:0]    smag;
	logic signed [17:0] w3;
	logic signed [18:0] d4m;
	logic signed [25:0] d3;
	logic [21:0]    d3c;
	logic [24:0]    q25;
	logic [11:0]    qc;
	logic signed [13:0] qv;
	logic [24:0]    msrc;

	// sample magnitudes over the low SAMPLE_BITS bits
	assign l_raw = left_sample[SW-1:0];
	assign r_raw = right_sample[SW-1:0];
	assign l_abs = l_raw[SW-1] ? (~l_raw + SW'(1)) : l_raw;
	assign r_abs = r_raw[SW-1] ? (~r_raw + SW'(1)) : r_raw;
	assign pair  = {1'b0, l_abs} + {1'b0, r_abs};
	assign psum  = {1'b0, peak_l_q} + {1'b0, peak_r_q} + 25'd1;

	assign sts.frame_end = last_in_frame || (count_q == CNT_W'(FRAME_MAX - 1));
	assign sts.div_done  = div_done;
	assign screen_x = sx_q;
	assign screen_y = sy_q;

	always_comb begin
		case (cmd.trig[2:1])
			2'd0:    pp = ph_xy_q;
			2'd1:    pp = ph_zw_q;
			default: pp = ph_xw_q;
		endcase
		if (cmd.trig[0])
			pp = pp + 16'd16384;
		smag = 15'((32'(r_q) * 32'(t_q)) >> 14);
		w3   = 18'((pa_q + pb_q + 36'sd8192) >>> 14);
		d4m  = $signed({2'b0, d4_q}) - {w3[17], w3};
		d3   = 26'sd49152 - {z3d_q[24], z3d_q};
		d3c  = (d3 < 26'sd256) ? 22'd256 : d3[21:0];
		msrc = (cmd.dsel == DSEL_SX) ? x3d_q : y3d_q;
		q25  = {1'b0, quo[23:0]};
		qc   = (quo > NW'(4095)) ? 12'd4095 : quo[11:0];
		qv   = $signed({2'b0, qc});
	end

	always_comb begin
		div_num = '0;
		div_den = '0;
		div_neg = 1'b0;
		case (cmd.dsel)
			DSEL_VOL: begin
				div_num = NW'({abs_sum_q, 15'b0});
				div_den = DW'(den_q);
			end
			DSEL_X: begin
				div_num = NW'({abs18(x3_q), 14'b0});
				div_den = DW'(den4_q);
				div_neg = x3_q[17];
			end
			DSEL_Y: begin
				div_num = NW'({abs18(y1_q), 14'b0});
				div_den = DW'(den4_q);
				div_neg = y1_q[17];
			end
			DSEL_Z: begin
				div_num = NW'({abs18(z2_q), 14'b0});
				div_den = DW'(den4_q);
				div_neg = z2_q[17];
			end
			DSEL_SX, DSEL_SY: begin
				div_num = NW'(prod_q);
				div_den = DW'(den3_q);
				div_neg = prod_neg_q;
			end
			default: ;
		endcase
	end

	adtp_div #(.NW(NW), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_l_q   <= '0;
			peak_r_q   <= '0;
			count_q    <= '0;
			abs_sum_q  <= '0;
			smoothed_q <= '0;
			ph_xy_q    <= '0;
			ph_zw_q    <= '0;
			ph_xw_q    <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					REG_PEAK_LEFT:  peak_l_q <= cfg_data;
					REG_PEAK_RIGHT: peak_r_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.acc) begin
				abs_sum_q <= abs_sum_q + ABS_W'(pair);
				count_q   <= count_q + 1'b1;
			end
			case (cmd.op)
				OP_SM1: begin
					abs_sum_q <= '0;
					count_q   <= '0;
				end
				OP_SM2:
					smoothed_q <= 16'((38'(sm_n_q) * RECIP10) >> 22);
				OP_PHASE: begin
					ph_xy_q <= ph_xy_q + phase_step(16'd209, 16'd417, smoothed_q);
					ph_zw_q <= ph_zw_q + phase_step(16'd313, 16'd522, smoothed_q);
					ph_xw_q <= ph_xw_q + phase_step(16'd156, 16'd313, smoothed_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dsel_l_q <= cmd.dsel;
			neg_l_q  <= div_neg;
		end
		if (div_done) begin
			case (dsel_l_q)
				DSEL_VOL: vol_q <= (quo > NW'(VOL_ONE)) ? VOL_ONE : quo[15:0];
				DSEL_X:   x3d_q <= neg_l_q ? -$signed(q25) : $signed(q25);
				DSEL_Y:   y3d_q <= neg_l_q ? -$signed(q25) : $signed(q25);
				DSEL_Z:   z3d_q <= neg_l_q ? -$signed(q25) : $signed(q25);
				DSEL_SX:  sx_q  <= sat12(14'sd63 + (neg_l_q ? -qv : qv));
				DSEL_SY:  sy_q  <= sat12(14'sd31 + (neg_l_q ? qv : -qv));
				default: ;
			endcase
		end
		case (cmd.op)
			OP_DEN:
				den_q <= DEN_VW'(count_q) * DEN_VW'(psum);
			OP_SM1:
				sm_n_q <= ({3'b0, smoothed_q} * 19'd7) + ({3'b0, vol_q} * 19'd3) + 19'd5;
			OP_PHASE: begin
				d4_q    <= 17'd39322 - 17'(smoothed_q >> 2);
				scale_q <= 15'd16640 + 15'((32'(smoothed_q) * 32'd5120) >> 15);
			end
			OP_SIN: begin
				case (cmd.step)
					3'd0: begin
						t_q    <= pp[14] ? (15'd16384 - {1'b0, pp[13:0]}) : {1'b0, pp[13:0]};
						sneg_q <= pp[15];
					end
					3'd1: t2_q <= 15'((32'(t_q) * 32'(t_q)) >> 14);
					3'd2: r_q  <= 16'd10512 - 16'((32'(t2_q) * 32'd1160) >> 14);
					3'd3: r_q  <= 16'd25736 - 16'((32'(r_q) * 32'(t2_q)) >> 14);
					default:
						trig_q[cmd.trig] <= sneg_q ? -$signed({2'b0, smag})
						                           : $signed({2'b0, smag});
				endcase
			end
			OP_ROT: begin
				case (cmd.step)
					3'd0: begin
						// trig_q: sin/cos of xy, zw, xw in that order
						x1_q <= pm(cmd.vert[0], trig_q[1]) - pm(cmd.vert[1], trig_q[0]);
						y1_q <= pm(cmd.vert[0], trig_q[0]) + pm(cmd.vert[1], trig_q[1]);
						z2_q <= pm(cmd.vert[2], trig_q[3]) - pm(cmd.vert[3], trig_q[2]);
						w2_q <= pm(cmd.vert[2], trig_q[2]) + pm(cmd.vert[3], trig_q[3]);
					end
					3'd1: begin
						pa_q <= x1_q * trig_q[5];
						pb_q <= w2_q * trig_q[4];
					end
					3'd2: x3_q <= 18'((pa_q - pb_q + 36'sd8192) >>> 14);
					3'd3: begin
						pa_q <= x1_q * trig_q[4];
						pb_q <= w2_q * trig_q[5];
					end
					default:
						den4_q <= (d4m < 19'sd256) ? 17'd256 : d4m[16:0];
				endcase
			end
			OP_DEN3:
				den3_q <= {2'b0, d3c, 8'b0};
			OP_MUL: begin
				prod_q     <= 39'(abs25(msrc)) * 39'(scale_q);
				prod_neg_q <= msrc[24];
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/adtp_ctrl.sv @@
// Controller: sequences accumulation, frame-end computation and vertex output.
module adtp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  adtp_pkg::sts_t sts,
	output adtp_pkg::cmd_t cmd
);
	import adtp_pkg::*;

	typedef enum logic [11:0] {
		S_ACC   = 12'b0000_0000_0001,
		S_DEN   = 12'b0000_0000_0010,
		S_VDIV  = 12'b0000_0000_0100,
		S_SM1   = 12'b0000_0000_1000,
		S_SM2   = 12'b0000_0001_0000,
		S_PHASE = 12'b0000_0010_0000,
		S_SIN   = 12'b0000_0100_0000,
		S_ROT   = 12'b0000_1000_0000,
		S_DIV   = 12'b0001_0000_0000,
		S_DEN3  = 12'b0010_0000_0000,
		S_MUL   = 12'b0100_0000_0000,
		S_OUT   = 12'b1000_0000_0000
	} state_t;

	state_t            state_q;
	logic [2:0]        step_q;
	logic [2:0]        trig_q;
	logic [VIDX_W-1:0] vert_q;
	dsel_t             dsel_q;
	logic              started_q;

	always_comb begin
		cmd           = '0;
		cmd.op        = OP_IDLE;
		cmd.step      = step_q;
		cmd.trig      = trig_q;
		cmd.vert      = vert_q;
		cmd.dsel      = dsel_q;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		case (state_q)
			S_ACC: begin
				in_ready = 1'b1;
				cmd.acc  = in_valid;
			end
			S_DEN:        cmd.op = OP_DEN;
			S_VDIV, S_DIV: cmd.div_start = !started_q;
			S_SM1:        cmd.op = OP_SM1;
			S_SM2:        cmd.op = OP_SM2;
			S_PHASE:      cmd.op = OP_PHASE;
			S_SIN:        cmd.op = OP_SIN;
			S_ROT:        cmd.op = OP_ROT;
			S_DEN3:       cmd.op = OP_DEN3;
			S_MUL:        cmd.op = OP_MUL;
			S_OUT:        out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_ACC;
			step_q    <= '0;
			trig_q    <= '0;
			vert_q    <= '0;
			dsel_q    <= DSEL_VOL;
			started_q <= 1'b0;
		end else begin
			case (state_q)
				S_ACC:
					if (in_valid && sts.frame_end) begin
						state_q <= S_DEN;
						dsel_q  <= DSEL_VOL;
					end
				S_DEN: state_q <= S_VDIV;
				S_VDIV:
					if (!started_q)
						started_q <= 1'b1;
					else if (sts.div_done) begin
						started_q <= 1'b0;
						state_q   <= S_SM1;
					end
				S_SM1: state_q <= S_SM2;
				S_SM2: state_q <= S_PHASE;
				S_PHASE: begin
					state_q <= S_SIN;
					step_q  <= '0;
					trig_q  <= '0;
				end
				S_SIN:
					if (step_q == 3'd4) begin
						step_q <= '0;
						if (trig_q == 3'd5) begin
							state_q <= S_ROT;
							vert_q  <= '0;
						end else
							trig_q <= trig_q + 1'b1;
					end else
						step_q <= step_q + 1'b1;
				S_ROT:
					if (step_q == 3'd4) begin
						step_q  <= '0;
						state_q <= S_DIV;
						dsel_q  <= DSEL_X;
					end else
						step_q <= step_q + 1'b1;
				S_DIV:
					if (!started_q)
						started_q <= 1'b1;
					else if (sts.div_done) begin
						started_q <= 1'b0;
						case (dsel_q)
							DSEL_X:  dsel_q <= DSEL_Y;
							DSEL_Y:  dsel_q <= DSEL_Z;
							DSEL_Z:  state_q <= S_DEN3;
							DSEL_SX: begin
								dsel_q  <= DSEL_SY;
								state_q <= S_MUL;
							end
							default: state_q <= S_OUT;
						endcase
					end
				S_DEN3: begin
					dsel_q  <= DSEL_SX;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_DIV;
				S_OUT:
					if (out_ready) begin
						if (vert_q == LAST_VTX) begin
							vert_q  <= '0;
							state_q <= S_ACC;
						end else begin
							vert_q  <= vert_q + 1'b1;
							state_q <= S_ROT;
						end
					end
				default: state_q <= S_ACC;
			endcase
		end
	end

endmodule

@@ rtl/audio_driven_tesseract_projection.sv @@
// Top level of the audio-driven tesseract projection block.
//
// Input channel (in_valid/in_ready): one stereo pair per transfer, with
// last_in_frame closing the frame.  While a frame is open one pair is taken
// every cycle; |left|+|right| is accumulated.  A frame also closes when the
// pair count reaches FRAME_MAX.
// At a frame end the block stops taking pairs, derives the frame volume,
// smooths it, advances the three rotation phases, evaluates six sines and
// then works out the 16 hypercube vertices one by one.
// Each vertex needs five divisions on a single shared restoring divider
// (NW = 51 at the default parameters) plus rotation, multiply and output
// steps; this divider sets the rate.
// Output channel (out_valid/out_ready): one vertex per transfer, vertex 0
// first, last_vertex high on vertex 15.  While the receiver stalls the
// vertex is held and no further work is done.
// Configuration (cfg_valid/cfg_ready): always ready; index 0 writes the left
// peak, index 1 the right peak, other indices are dropped.  Write only
// while the block is idle.
// Reset clears the peaks, the frame sums, the smoothed volume and phases.
module audio_driven_tesseract_projection #(
	parameter int FRAME_MAX   = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [adtp_pkg::SAMPLE_W-1:0]       left_sample,
	input  logic [adtp_pkg::SAMPLE_W-1:0]       right_sample,
	input  logic                                last_in_frame,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [adtp_pkg::VIDX_W-1:0]         vertex_index,
	output logic signed [adtp_pkg::COORD_W-1:0] screen_x,
	output logic signed [adtp_pkg::COORD_W-1:0] screen_y,
	output logic                                last_vertex,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [adtp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [adtp_pkg::PEAK_W-1:0]         cfg_data
);
	import adtp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// configuration is taken in any cycle
	assign cfg_ready = 1'b1;

	// vertex number comes straight from the controller's vertex counter
	assign vertex_index = cmd.vert;
	assign last_vertex  = (cmd.vert == LAST_VTX);

	adtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	adtp_dp #(
		.FRAME_MAX   (FRAME_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.last_in_frame (last_in_frame),
		.cfg_wr        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.screen_x      (screen_x),
		.screen_y      (screen_y)
	);

endmodule
